>>> hw/rtl/mht_pkg.sv
// Shared types and codes for the max-heap replace-top block.
// Used by mht_mem, max_heap_replace_top and mht_checker; depends on nothing.
package mht_pkg;

	// Opcode of one input beat
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_BUILD   = 2'd1,
		OP_REPLACE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// Status of one result beat
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_RDCH,
		S_CMP,
		S_RDTOP,
		S_DONE
	} state_t;

	// One heap slot: signed Q16.16 key with its action tag
	typedef struct packed {
		logic signed [31:0] key;
		logic [15:0]        tag;
	} entry_t;

endpackage

>>> hw/rtl/mht_mem.sv
// Heap storage: one write port and two registered read ports.
// Depends on mht_pkg for the entry type.
module mht_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  mht_pkg::entry_t      wdata,
	input  logic                 re_a,
	input  logic [AW-1:0]        raddr_a,
	output mht_pkg::entry_t      rdata_a,
	input  logic                 re_b,
	input  logic [AW-1:0]        raddr_b,
	output mht_pkg::entry_t      rdata_b
);

	mht_pkg::entry_t mem_q [DEPTH];

	// Write the selected slot
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register both read ports; data holds while a port is idle
	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

>>> hw/rtl/max_heap_replace_top.sv
// Binary max-heap with load, build, replace-top and clear; uses mht_pkg and mht_mem.
// Load and clear go straight to the root read; replace sifts the new key down from the root.
// Build sifts each non-leaf node down in turn, last to first, and skips that with fewer than two entries.
// Throughput: one item at a time, set by the single sift sequencer and its
// read-compare-write round trip on the heap memory; a stalled result beat holds off the next item.
// Reset: asynchronous, clears the count and handshake state; heap contents stay undefined.
module max_heap_replace_top #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] new_key,
	input  logic [15:0]        action_tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] top_key,
	output logic [15:0]        top_action,
	output logic [6:0]         entry_count,
	output logic [1:0]         status
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

	mht_pkg::state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [AW-1:0]      node_q;
	logic [AW-1:0]      bld_q;
	logic               repl_q;
	logic               first_q;
	logic signed [31:0] rkey_q;
	mht_pkg::entry_t    moved_q;
	mht_pkg::status_t   status_q;
	logic               out_valid_q;

	logic               we;
	logic [AW-1:0]      waddr;
	mht_pkg::entry_t    wdata;
	logic               re_a, re_b;
	logic [AW-1:0]      raddr_a, raddr_b;
	mht_pkg::entry_t    rdata_a, rdata_b;

	logic [AW+1:0]      left_w, right_w, cnt_w;
	logic               left_ok, right_ok;
	logic               take_left, take_right;
	mht_pkg::entry_t    moved_w;
	logic [CW-1:0]      half_w;
	logic               node_end;
	logic               in_fire;
	logic               out_load;
	logic [CW+6:0]      cnt_ext;

	mht_mem #(
		.DEPTH(HEAP_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re_a   (re_a),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.re_b   (re_b),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// Child indices and bounds of the current node
	assign left_w   = {1'b0, node_q, 1'b1};
	assign right_w  = left_w + (AW+2)'(1);
	assign cnt_w    = (AW+2)'(count_q);
	assign left_ok  = left_w < cnt_w;
	assign right_ok = right_w < cnt_w;
	assign half_w   = count_q >> 1;

	// Element being sifted: freshly read on the first level, held after that
	always_comb begin
		moved_w = moved_q;
		if (first_q) begin
			moved_w = rdata_a;
			if (repl_q) begin
				moved_w.key = rkey_q;
			end
		end
	end

	// Pick the winner: left only if strictly greater, right only if beats the winner
	always_comb begin
		take_left  = left_ok && ($signed(rdata_a.key) > $signed(moved_q.key));
		take_right = 1'b0;
		if (right_ok) begin
			if (take_left) begin
				take_right = $signed(rdata_b.key) > $signed(rdata_a.key);
			end else begin
				take_right = $signed(rdata_b.key) > $signed(moved_q.key);
			end
		end
	end

	assign in_fire  = in_valid && in_ready;
	assign in_ready = (state_q == mht_pkg::S_IDLE);
	assign out_load = (state_q == mht_pkg::S_DONE) && (!out_valid_q || out_ready);
	assign node_end = (state_q == mht_pkg::S_CMP) && !take_left && !take_right;

	// Next state and memory controls
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = node_q;
		wdata   = moved_q;
		re_a    = 1'b0;
		re_b    = 1'b0;
		raddr_a = node_q;
		raddr_b = node_q;
		unique case (state_q)
			mht_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (mht_pkg::op_t'(opcode))
						mht_pkg::OP_LOAD: begin
							if (count_q < DEPTH_C) begin
								we    = 1'b1;
								waddr = count_q[AW-1:0];
								wdata = {new_key, action_tag};
							end
							state_d = mht_pkg::S_RDTOP;
						end
						mht_pkg::OP_BUILD: begin
							state_d = (half_w == '0) ? mht_pkg::S_RDTOP : mht_pkg::S_FETCH;
						end
						mht_pkg::OP_REPLACE: begin
							state_d = (count_q == '0) ? mht_pkg::S_RDTOP : mht_pkg::S_FETCH;
						end
						mht_pkg::OP_CLEAR: begin
							state_d = mht_pkg::S_RDTOP;
						end
					endcase
				end
			end
			mht_pkg::S_FETCH: begin
				re_a    = 1'b1;
				state_d = mht_pkg::S_RDCH;
			end
			mht_pkg::S_RDCH: begin
				re_a    = left_ok;
				re_b    = right_ok;
				raddr_a = left_w[AW-1:0];
				raddr_b = right_w[AW-1:0];
				state_d = mht_pkg::S_CMP;
			end
			mht_pkg::S_CMP: begin
				we = 1'b1;
				if (take_right) begin
					wdata   = rdata_b;
					state_d = mht_pkg::S_RDCH;
				end else if (take_left) begin
					wdata   = rdata_a;
					state_d = mht_pkg::S_RDCH;
				end else if (repl_q || bld_q == '0) begin
					state_d = mht_pkg::S_RDTOP;
				end else begin
					state_d = mht_pkg::S_FETCH;
				end
			end
			mht_pkg::S_RDTOP: begin
				re_a    = 1'b1;
				raddr_a = '0;
				state_d = mht_pkg::S_DONE;
			end
			mht_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = mht_pkg::S_IDLE;
				end
			end
			default: state_d = mht_pkg::S_IDLE;
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mht_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track the entry count and the item status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= mht_pkg::ST_OK;
		end else if (in_fire) begin
			status_q <= mht_pkg::ST_OK;
			unique case (mht_pkg::op_t'(opcode))
				mht_pkg::OP_LOAD: begin
					if (count_q < DEPTH_C) begin
						count_q <= count_q + CW'(1);
					end else begin
						status_q <= mht_pkg::ST_FULL;
					end
				end
				mht_pkg::OP_BUILD: begin
				end
				mht_pkg::OP_REPLACE: begin
					if (count_q == '0) begin
						status_q <= mht_pkg::ST_EMPTY;
					end
				end
				mht_pkg::OP_CLEAR: begin
					count_q <= '0;
				end
			endcase
		end
	end

	// Walk flags: set up on accept, clear the first-level flag after the child read, set it when a node ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			repl_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				repl_q  <= (mht_pkg::op_t'(opcode) == mht_pkg::OP_REPLACE);
				first_q <= 1'b1;
			end else if (state_q == mht_pkg::S_RDCH) begin
				first_q <= 1'b0;
			end else if (node_end) begin
				first_q <= 1'b1;
			end
		end
	end

	// Datapath registers of the sift walk
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rkey_q <= new_key;
			if (mht_pkg::op_t'(opcode) == mht_pkg::OP_REPLACE) begin
				node_q <= '0;
				bld_q  <= '0;
			end else begin
				node_q <= AW'(half_w - CW'(1));
				bld_q  <= AW'(half_w - CW'(1));
			end
		end
		if (state_q == mht_pkg::S_RDCH) begin
			moved_q <= moved_w;
		end
		if (state_q == mht_pkg::S_CMP) begin
			if (take_right) begin
				node_q <= right_w[AW-1:0];
			end else if (take_left) begin
				node_q <= left_w[AW-1:0];
			end else if (!repl_q && bld_q != '0) begin
				node_q <= bld_q - AW'(1);
				bld_q  <= bld_q - AW'(1);
			end
		end
	end

	// Output register: load the result beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cnt_ext = (CW+7)'(count_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (count_q == '0) begin
				top_key    <= '0;
				top_action <= '0;
			end else begin
				top_key    <= rdata_a.key;
				top_action <= rdata_a.tag;
			end
			entry_count <= cnt_ext[6:0];
			status      <= status_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/mht_checker.sv
// Port-level checks for max_heap_replace_top, bound to every instance.
// Depends on mht_pkg for the status codes.
module mht_checker #(
	parameter int HEAP_DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] top_key,
	input logic [15:0]        top_action,
	input logic [6:0]         entry_count,
	input logic [1:0]         status
);

	// A stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_key) && $stable(top_action)
			&& $stable(entry_count) && $stable(status))
		else $error("result beat changed while stalled");

	// An empty heap reports a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == 7'd0 |-> top_key == 32'sd0 && top_action == 16'd0)
		else $error("empty heap shows a nonzero top");

	// Replace on empty only when the count is zero
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mht_pkg::ST_EMPTY |-> entry_count == 7'd0)
		else $error("replace-when-empty status with entries held");

	// Full status only at full depth
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mht_pkg::ST_FULL |->
			(HEAP_DEPTH > 127) || (entry_count == 7'(HEAP_DEPTH)))
		else $error("load-when-full status below full depth");

	// Count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (HEAP_DEPTH > 127) || (int'(entry_count) <= HEAP_DEPTH))
		else $error("entry count beyond heap depth");

endmodule

bind max_heap_replace_top mht_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_mht_checker (.*);

>>> verif/max_heap_replace_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for max_heap_replace_top: directed table, then random heap sessions.
// Depends on mht_pkg (opcode, status and entry types) and the max_heap_replace_top RTL.
module max_heap_replace_top_tb;

	localparam int HEAP_DEPTH = 64;
	localparam int TARGET_ITEMS = 650;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;

	// Root, count and status seen after one item
	typedef struct packed {
		logic signed [31:0] key;
		logic [15:0]        tag;
		logic [6:0]         count;
		mht_pkg::status_t   st;
	} heap_result_t;

	// One directed row; the want fields count only where fixed is set
	typedef struct packed {
		mht_pkg::op_t     op;
		logic [31:0]      key;
		logic [15:0]      tag;
		bit               fixed;
		logic [31:0]      want_key;
		logic [15:0]      want_tag;
		logic [6:0]       want_count;
		mht_pkg::status_t want_st;
	} stim_row_t;

	localparam int N_ROWS = 24;
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		// empty heap after reset
		'{mht_pkg::OP_REPLACE, 32'h12345678, 16'hBEEF, 1'b1, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_EMPTY},
		'{mht_pkg::OP_BUILD, 32'h0, 16'h0, 1'b1, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_CLEAR, 32'h0, 16'h0, 1'b1, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		// extremes of key and tag, unordered loads, ties
		'{mht_pkg::OP_LOAD, 32'h7FFFFFFF, 16'hFFFF, 1'b1, 32'h7FFFFFFF, 16'hFFFF, 7'd1,
		  mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h80000000, 16'h0000, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h00000000, 16'h1234, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'hFFFFFFFF, 16'h8000, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h00010000, 16'h0001, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h00010000, 16'h0002, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_BUILD, 32'h0, 16'h0, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		// sift the minimum to a leaf, then a tie, then the maximum
		'{mht_pkg::OP_REPLACE, 32'h80000000, 16'h0000, 1'b0, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_OK},
		'{mht_pkg::OP_REPLACE, 32'h00010000, 16'h5A5A, 1'b0, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_OK},
		'{mht_pkg::OP_REPLACE, 32'h7FFFFFFF, 16'hA5A5, 1'b0, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_OK},
		'{mht_pkg::OP_CLEAR, 32'h0, 16'h0, 1'b1, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_REPLACE, 32'hFFFF0000, 16'hFFFF, 1'b1, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_EMPTY},
		// equal children: left wins on build, root stays on an equal replace
		'{mht_pkg::OP_LOAD, 32'h00030000, 16'h000A, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h00070000, 16'h000B, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h00070000, 16'h000C, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_BUILD, 32'h0, 16'h0, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_REPLACE, 32'h00070000, 16'hFFFF, 1'b0, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_OK},
		'{mht_pkg::OP_REPLACE, 32'h00050000, 16'h0000, 1'b0, 32'h0, 16'h0, 7'd0,
		  mht_pkg::ST_OK},
		'{mht_pkg::OP_LOAD, 32'h80000000, 16'h5555, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_BUILD, 32'h0, 16'h0, 1'b0, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK},
		'{mht_pkg::OP_CLEAR, 32'h0, 16'h0, 1'b1, 32'h0, 16'h0, 7'd0, mht_pkg::ST_OK}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic signed [31:0] new_key;
	logic [15:0]        action_tag;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] top_key;
	logic [15:0]        top_action;
	logic [6:0]         entry_count;
	logic [1:0]         status;

	// Shadow heap kept in step with the block
	mht_pkg::entry_t heap_slots [HEAP_DEPTH];
	int unsigned     heap_fill;
	heap_result_t    pending_tops [$];
	int              items_sent;
	int              mismatches;
	int              idle_cycles;
	bit              tx_burst;

	max_heap_replace_top #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.new_key(new_key),
		.action_tag(action_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_key(top_key),
		.top_action(top_action),
		.entry_count(entry_count),
		.status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sift one node down the shadow heap; ties leave the node in place
	function automatic void heap_sift_down(int unsigned node);
		int unsigned     best;
		int unsigned     left_idx;
		int unsigned     right_idx;
		mht_pkg::entry_t held;
		while (node < heap_fill) begin
			best = node;
			left_idx = 2 * node + 1;
			right_idx = 2 * node + 2;
			if (left_idx < heap_fill &&
			    $signed(heap_slots[left_idx].key) > $signed(heap_slots[best].key))
				best = left_idx;
			if (right_idx < heap_fill &&
			    $signed(heap_slots[right_idx].key) > $signed(heap_slots[best].key))
				best = right_idx;
			if (best == node)
				break;
			held = heap_slots[node];
			heap_slots[node] = heap_slots[best];
			heap_slots[best] = held;
			node = best;
		end
	endfunction

	// Apply one item to the shadow heap and return the root it leaves
	function automatic heap_result_t heap_apply(mht_pkg::op_t op, logic [31:0] key,
	                                            logic [15:0] tag);
		heap_result_t r;
		int unsigned  i;
		r.st = mht_pkg::ST_OK;
		case (op)
			mht_pkg::OP_LOAD: begin
				if (heap_fill >= HEAP_DEPTH) begin
					r.st = mht_pkg::ST_FULL;
				end else begin
					heap_slots[heap_fill].key = key;
					heap_slots[heap_fill].tag = tag;
					heap_fill++;
				end
			end
			mht_pkg::OP_BUILD: begin
				for (i = heap_fill / 2; i > 0; i--)
					heap_sift_down(i - 1);
			end
			mht_pkg::OP_REPLACE: begin
				if (heap_fill == 0) begin
					r.st = mht_pkg::ST_EMPTY;
				end else begin
					heap_slots[0].key = key;
					heap_sift_down(0);
				end
			end
			default: heap_fill = 0;
		endcase
		r.key = (heap_fill != 0) ? heap_slots[0].key : 32'sd0;
		r.tag = (heap_fill != 0) ? heap_slots[0].tag : 16'd0;
		r.count = heap_fill[6:0];
		return r;
	endfunction

	// Mix full-range keys with narrow ones that tie often and with the extremes
	function automatic logic [31:0] draw_key();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return ($urandom_range(0, 8) - 4) << 16;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'hFFFFFFFF;
					default: return 32'h00000000;
				endcase
			end
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	// Present one beat after a random gap (none in a burst), hold it until taken, then record the expected root
	task automatic send_beat(mht_pkg::op_t op, logic [31:0] key, logic [15:0] tag, bit fixed,
	                         heap_result_t want);
		int           gap;
		heap_result_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		new_key <= key;
		action_tag <= tag;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = heap_apply(op, key, tag);
		pending_tops.insert(pending_tops.size(), fixed ? want : predicted);
		items_sent++;
	endtask

	task automatic send_random(mht_pkg::op_t op);
		send_beat(op, draw_key(), 16'($urandom_range(0, 65535)), 1'b0, '0);
	endtask

	// Hold off new beats until every expected root has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tops.size() != 0) @(posedge clk);
	endtask

	// Well-formed session: optional clear, loads, build, then replaces with some late loads
	task automatic run_heap_session(int n_loads, bit start_clear);
		int n_replace;
		if (start_clear)
			send_random(mht_pkg::OP_CLEAR);
		repeat (n_loads) send_random(mht_pkg::OP_LOAD);
		send_random(mht_pkg::OP_BUILD);
		n_replace = $urandom_range(1, 10);
		repeat (n_replace) begin
			if ($urandom_range(0, 7) == 0) begin
				send_random(mht_pkg::OP_LOAD);
				send_random(mht_pkg::OP_BUILD);
			end
			send_random(mht_pkg::OP_REPLACE);
		end
	endtask

	// Stimulus
	initial begin
		heap_result_t want;
		int           n_loads;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = mht_pkg::OP_LOAD;
		new_key = '0;
		action_tag = '0;
		heap_fill = 0;
		items_sent = 0;
		tx_burst = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < N_ROWS; r++) begin
			want.key = DIRECTED_ROWS[r].want_key;
			want.tag = DIRECTED_ROWS[r].want_tag;
			want.count = DIRECTED_ROWS[r].want_count;
			want.st = DIRECTED_ROWS[r].want_st;
			send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].tag,
			          DIRECTED_ROWS[r].fixed, want);
		end

		// fill past full once, back to back after a full drain
		drain_results();
		tx_burst = 1'b1;
		run_heap_session(HEAP_DEPTH + 2, 1'b1);

		// random sessions, mostly well-formed, some noise
		while (items_sent < TARGET_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				drain_results();
			if ($urandom_range(0, 9) < 7) begin
				n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(33, HEAP_DEPTH + 2)
				                                     : $urandom_range(1, 12);
				run_heap_session(n_loads, $urandom_range(0, 4) != 0);
			end else begin
				repeat ($urandom_range(1, 6))
					send_random(mht_pkg::op_t'($urandom_range(0, 3)));
			end
		end
		in_valid <= 1'b0;

		// let the last roots arrive and watch for strays
		while (pending_tops.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_tops.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Result side: random stalls with bursts of steady ready, check each beat
	initial begin
		int           stall;
		int           rx_burst_left;
		heap_result_t want;
		out_ready = 1'b0;
		mismatches = 0;
		rx_burst_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_burst_left > 0) begin
				stall = 0;
				rx_burst_left--;
			end else begin
				stall = $urandom_range(0, 15);
				if ($urandom_range(0, 19) == 0)
					rx_burst_left = 25;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_tops.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result key %h tag %h count %0d status %0d",
					         $realtime, top_key, top_action, entry_count, status);
				mismatches++;
			end else begin
				want = pending_tops.pop_front();
				if (top_key !== want.key || top_action !== want.tag ||
				    entry_count !== want.count || status !== want.st) begin
					if (mismatches < 10) begin
						$write("%0t: mismatch, expected key %h tag %h count %0d status %0d,",
						       $realtime, want.key, want.tag, want.count, want.st);
						$display(" got key %h tag %h count %0d status %0d",
						         top_key, top_action, entry_count, status);
					end
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
